/* design/kufm_pkg.sv */
// ----------------------------------------------------------------------------
// kufm_pkg: shared types and microprogram for the union-find merge unit
// Holds the field widths, the control word layout, the datapath status
// bundle and the read-only control store of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package kufm_pkg;

  localparam int VTX_W = 10;
  localparam int WGT_W = 40;
  localparam int SUM_W = 48;
  localparam int CNT_W = 10;
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t S_IDLE     = 5'd0;
  localparam pc_t S_TEST_CLR = 5'd1;
  localparam pc_t S_TEST_BAD = 5'd2;
  localparam pc_t S_FA_RD    = 5'd3;
  localparam pc_t S_FA_CHK   = 5'd4;
  localparam pc_t S_CA_INIT  = 5'd5;
  localparam pc_t S_CA_RD    = 5'd6;
  localparam pc_t S_CA_CHK   = 5'd7;
  localparam pc_t S_FB_INIT  = 5'd8;
  localparam pc_t S_FB_RD    = 5'd9;
  localparam pc_t S_FB_CHK   = 5'd10;
  localparam pc_t S_CB_INIT  = 5'd11;
  localparam pc_t S_CB_RD    = 5'd12;
  localparam pc_t S_CB_CHK   = 5'd13;
  localparam pc_t S_LINK     = 5'd14;
  localparam pc_t S_CLR_WR   = 5'd15;
  localparam pc_t S_CLR_END  = 5'd16;
  localparam pc_t S_RESULT   = 5'd17;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_RD_V,
    MEM_WR_V_R,
    MEM_WR_R_RA,
    MEM_WR_CNT
  } mem_op_t;

  typedef enum logic [1:0] {
    V_HOLD,
    V_A,
    V_B,
    V_RDATA
  } v_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_ZERO,
    CNT_INC
  } cnt_op_t;

  typedef enum logic [1:0] {
    TOT_HOLD,
    TOT_CLEAR,
    TOT_LINK
  } tot_op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_REQ,
    C_CLEAR,
    C_BAD,
    C_NOT_ROOT,
    C_NOT_LAST,
    C_INIT,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    mem_op_t mem_op;
    v_op_t   v_op;
    logic    r_ld;
    logic    ra_ld;
    cnt_op_t cnt_op;
    tot_op_t tot_op;
    logic    in_rdy;
    logic    out_ld;
    logic    init_clr;
    cond_t   cond;
    pc_t     nxt_t;
    pc_t     nxt_f;
  } ucw_t;

  typedef struct packed {
    logic is_clear;
    logic bad;
    logic not_root;
    logic not_last;
  } dp_stat_t;

  function automatic ucw_t ucode(input pc_t pc);
    ucw_t cw;
    cw = '0;
    cw.nxt_t = S_IDLE;
    cw.nxt_f = S_IDLE;
    unique case (pc)
      S_IDLE: begin
        cw.in_rdy = 1'b1;
        cw.cond   = C_NO_REQ;
        cw.nxt_t  = S_IDLE;
        cw.nxt_f  = S_TEST_CLR;
      end
      S_TEST_CLR: begin
        cw.cnt_op = CNT_ZERO;
        cw.cond   = C_CLEAR;
        cw.nxt_t  = S_CLR_WR;
        cw.nxt_f  = S_TEST_BAD;
      end
      S_TEST_BAD: begin
        cw.v_op  = V_A;
        cw.cond  = C_BAD;
        cw.nxt_t = S_RESULT;
        cw.nxt_f = S_FA_RD;
      end
      S_FA_RD: begin
        cw.mem_op = MEM_RD_V;
        cw.nxt_f  = S_FA_CHK;
      end
      S_FA_CHK: begin
        cw.r_ld  = 1'b1;
        cw.v_op  = V_RDATA;
        cw.cond  = C_NOT_ROOT;
        cw.nxt_t = S_FA_RD;
        cw.nxt_f = S_CA_INIT;
      end
      S_CA_INIT: begin
        cw.v_op  = V_A;
        cw.nxt_f = S_CA_RD;
      end
      S_CA_RD: begin
        cw.mem_op = MEM_RD_V;
        cw.nxt_f  = S_CA_CHK;
      end
      S_CA_CHK: begin
        cw.mem_op = MEM_WR_V_R;
        cw.v_op   = V_RDATA;
        cw.cond   = C_NOT_ROOT;
        cw.nxt_t  = S_CA_RD;
        cw.nxt_f  = S_FB_INIT;
      end
      S_FB_INIT: begin
        cw.ra_ld = 1'b1;
        cw.v_op  = V_B;
        cw.nxt_f = S_FB_RD;
      end
      S_FB_RD: begin
        cw.mem_op = MEM_RD_V;
        cw.nxt_f  = S_FB_CHK;
      end
      S_FB_CHK: begin
        cw.r_ld  = 1'b1;
        cw.v_op  = V_RDATA;
        cw.cond  = C_NOT_ROOT;
        cw.nxt_t = S_FB_RD;
        cw.nxt_f = S_CB_INIT;
      end
      S_CB_INIT: begin
        cw.v_op  = V_B;
        cw.nxt_f = S_CB_RD;
      end
      S_CB_RD: begin
        cw.mem_op = MEM_RD_V;
        cw.nxt_f  = S_CB_CHK;
      end
      S_CB_CHK: begin
        cw.mem_op = MEM_WR_V_R;
        cw.v_op   = V_RDATA;
        cw.cond   = C_NOT_ROOT;
        cw.nxt_t  = S_CB_RD;
        cw.nxt_f  = S_LINK;
      end
      S_LINK: begin
        cw.mem_op = MEM_WR_R_RA;
        cw.tot_op = TOT_LINK;
        cw.nxt_t  = S_RESULT;
        cw.nxt_f  = S_RESULT;
      end
      S_CLR_WR: begin
        cw.mem_op = MEM_WR_CNT;
        cw.cnt_op = CNT_INC;
        cw.cond   = C_NOT_LAST;
        cw.nxt_t  = S_CLR_WR;
        cw.nxt_f  = S_CLR_END;
      end
      S_CLR_END: begin
        cw.tot_op   = TOT_CLEAR;
        cw.init_clr = 1'b1;
        cw.cond     = C_INIT;
        cw.nxt_t    = S_IDLE;
        cw.nxt_f    = S_RESULT;
      end
      S_RESULT: begin
        cw.out_ld = 1'b1;
        cw.cond   = C_OUT_BUSY;
        cw.nxt_t  = S_RESULT;
        cw.nxt_f  = S_IDLE;
      end
      default: begin
        cw.nxt_t = S_IDLE;
        cw.nxt_f = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

/* design/kufm_datapath.sv */
// ----------------------------------------------------------------------------
// kufm_datapath: parent table, walk registers and running totals
// Executes one control word per cycle: a single-port parent memory with
// registered read data, the walk pointer and root registers, the clear
// sweep counter, the saturating weight sum and the merge count.
// ----------------------------------------------------------------------------
`default_nettype none

module kufm_datapath
  import kufm_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int WEIGHT_BITS  = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ucw_t             cw,
  input  wire logic             item_ld,
  input  wire logic             in_req_type,
  input  wire logic [VTX_W-1:0] in_first_vertex,
  input  wire logic [VTX_W-1:0] in_second_vertex,
  input  wire logic [WGT_W-1:0] in_edge_weight,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  output dp_stat_t              stat,
  output logic                  merged,
  output logic                  bad_vertex,
  output logic [SUM_W-1:0]      total_weight,
  output logic [CNT_W-1:0]      components_left
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int EW = (NW > CFG_W) ? NW : CFG_W;
  localparam logic [WGT_W-1:0] W_MASK =
    (WEIGHT_BITS >= WGT_W) ? {WGT_W{1'b1}} : WGT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  logic [AW-1:0]    mem [MAX_VERTICES];
  logic [AW-1:0]    rdata_r;
  logic [AW-1:0]    v_r, r_r, ra_r, cnt_r;
  logic [VTX_W-1:0] a_r, b_r;
  logic [WGT_W-1:0] w_r;
  logic             req_r, bad_r, merged_r;
  logic [CFG_W-1:0] vcount_r;
  logic [SUM_W-1:0] sum_r;
  logic [EW-1:0]    count_r;

  logic [EW-1:0]    n_eff;
  logic             item_bad;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    wdata;
  logic             we;
  logic             differ;
  logic [SUM_W:0]   sum_ext;

  assign n_eff = (EW'(vcount_r) > EW'(MAX_VERTICES)) ? EW'(MAX_VERTICES) : EW'(vcount_r);
  assign item_bad = in_req_type &&
                    ((EW'(in_first_vertex) >= n_eff) || (EW'(in_second_vertex) >= n_eff));
  assign differ  = (ra_r != r_r);
  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(w_r);

  always_comb begin
    addr  = v_r;
    wdata = r_r;
    we    = 1'b0;
    unique case (cw.mem_op)
      MEM_NONE: begin
        addr = v_r;
      end
      MEM_RD_V: begin
        addr = v_r;
      end
      MEM_WR_V_R: begin
        addr  = v_r;
        wdata = r_r;
        we    = 1'b1;
      end
      MEM_WR_R_RA: begin
        addr  = r_r;
        wdata = ra_r;
        we    = 1'b1;
      end
      MEM_WR_CNT: begin
        addr  = cnt_r;
        wdata = cnt_r;
        we    = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (cw.mem_op == MEM_RD_V) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      vcount_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      unique case (cw.cnt_op)
        CNT_HOLD: cnt_r <= cnt_r;
        CNT_ZERO: cnt_r <= '0;
        CNT_INC:  cnt_r <= cnt_r + AW'(1);
        default:  cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_ld) begin
      req_r    <= in_req_type;
      a_r      <= in_first_vertex;
      b_r      <= in_second_vertex;
      w_r      <= in_edge_weight & W_MASK;
      bad_r    <= item_bad;
      merged_r <= 1'b0;
    end
    unique case (cw.v_op)
      V_HOLD:  v_r <= v_r;
      V_A:     v_r <= AW'(a_r);
      V_B:     v_r <= AW'(b_r);
      V_RDATA: v_r <= rdata_r;
      default: v_r <= v_r;
    endcase
    if (cw.r_ld) begin
      r_r <= v_r;
    end
    if (cw.ra_ld) begin
      ra_r <= r_r;
    end
    unique case (cw.tot_op)
      TOT_HOLD: begin
        sum_r <= sum_r;
      end
      TOT_CLEAR: begin
        sum_r   <= '0;
        count_r <= (n_eff == '0) ? '0 : n_eff - EW'(1);
      end
      TOT_LINK: begin
        merged_r <= differ;
        if (differ) begin
          sum_r <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
          if (count_r != '0) begin
            count_r <= count_r - EW'(1);
          end
        end
      end
      default: begin
        sum_r <= sum_r;
      end
    endcase
  end

  assign stat.is_clear = !req_r;
  assign stat.bad      = bad_r;
  assign stat.not_root = (rdata_r != v_r);
  assign stat.not_last = (cnt_r != LAST_IDX);

  assign merged          = merged_r;
  assign bad_vertex      = bad_r;
  assign total_weight    = sum_r;
  assign components_left = count_r[CNT_W-1:0];

endmodule

`default_nettype wire

/* design/kruskal_union_find_merge_unit.sv */
// ----------------------------------------------------------------------------
// kruskal_union_find_merge_unit: Kruskal merge stage over a union-find table
// Each request is either a clear or an edge. An edge finds the roots of both
// endpoints, points every vertex on both paths at its root, and links the
// second root under the first when they differ, adding the weight to a
// saturating total. Every request returns exactly one result.
//
// The in_ channel takes one request at a time; the out_ channel holds the
// result in an output register, so the next request is accepted while a
// result still waits for out_ready. A stalled receiver only holds the block
// when a second result is ready to be written.
// The walk is bound by the single memory port, one read or write per cycle.
// An endpoint at or above the vertex count returns without a walk. A clear
// sweeps the whole table, one entry a cycle. After reset the same sweep runs
// before the first request is accepted; configuration writes are taken at any
// time.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_merge_unit
  import kufm_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int WEIGHT_BITS  = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_req_type,
  input  wire logic [VTX_W-1:0] in_first_vertex,
  input  wire logic [VTX_W-1:0] in_second_vertex,
  input  wire logic [WGT_W-1:0] in_edge_weight,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_merged,
  output logic [SUM_W-1:0]      out_total_weight,
  output logic [CNT_W-1:0]      out_components_left,
  output logic                  out_bad_vertex
);

  pc_t              pc_r, pc_nxt;
  ucw_t             cw;
  dp_stat_t         stat;
  logic             init_r;
  logic             cond_hit;
  logic             out_busy;
  logic             item_ld;
  logic             res_ld;
  logic             dp_merged, dp_bad;
  logic [SUM_W-1:0] dp_total;
  logic [CNT_W-1:0] dp_count;

  logic             out_valid_r;
  logic             out_merged_r;
  logic [SUM_W-1:0] out_total_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_bad_r;

  assign cw       = ucode(pc_r);
  assign in_ready = cw.in_rdy;
  assign item_ld  = in_valid && cw.in_rdy;
  assign out_busy = out_valid_r && !out_ready;
  assign res_ld   = cw.out_ld && !out_busy;

  always_comb begin
    unique case (cw.cond)
      C_NONE:     cond_hit = 1'b0;
      C_NO_REQ:   cond_hit = !in_valid;
      C_CLEAR:    cond_hit = stat.is_clear;
      C_BAD:      cond_hit = stat.bad;
      C_NOT_ROOT: cond_hit = stat.not_root;
      C_NOT_LAST: cond_hit = stat.not_last;
      C_INIT:     cond_hit = init_r;
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? cw.nxt_t : cw.nxt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_CLR_WR;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cw.init_clr) begin
        init_r <= 1'b0;
      end
      if (res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld) begin
      out_merged_r <= dp_merged;
      out_total_r  <= dp_total;
      out_count_r  <= dp_count;
      out_bad_r    <= dp_bad;
    end
  end

  kufm_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cw               (cw),
    .item_ld          (item_ld),
    .in_req_type      (in_req_type),
    .in_first_vertex  (in_first_vertex),
    .in_second_vertex (in_second_vertex),
    .in_edge_weight   (in_edge_weight),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .stat             (stat),
    .merged           (dp_merged),
    .bad_vertex       (dp_bad),
    .total_weight     (dp_total),
    .components_left  (dp_count)
  );

  assign out_valid           = out_valid_r;
  assign out_merged          = out_merged_r;
  assign out_total_weight    = out_total_r;
  assign out_components_left = out_count_r;
  assign out_bad_vertex      = out_bad_r;

endmodule

`default_nettype wire

/* dv/mst_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_check_pkg: expected results for the union-find merge unit
// Keeps a private copy of the parent table, the running weight total and the
// merge count, works out the result of every accepted request, and compares
// each result from the block with the oldest one still outstanding.
// ----------------------------------------------------------------------------
package mst_check_pkg;

  import kufm_pkg::*;

  localparam int NUM_VERTICES = 1024;
  localparam int REPORT_LIMIT = 10;

  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_EDGE  = 1'b1;

  typedef struct packed {
    logic             merged;
    logic [SUM_W-1:0] total_weight;
    logic [CNT_W-1:0] components_left;
    logic             bad_vertex;
  } merge_result_t;

  class mst_scoreboard;

    logic [VTX_W-1:0] parent_of [NUM_VERTICES];
    logic [SUM_W-1:0] weight_total;
    logic [CNT_W-1:0] merges_left;
    logic [CFG_W-1:0] vertex_count;
    merge_result_t    expected_q [$];
    int unsigned      mismatches;

    function new();
      vertex_count = CFG_RESET;
      mismatches   = 0;
      clear_table();
    endfunction

    function int usable_count();
      return (vertex_count > NUM_VERTICES) ? NUM_VERTICES : int'(vertex_count);
    endfunction

    function void set_vertex_count(logic [CFG_W-1:0] value);
      vertex_count = value;
    endfunction

    function void clear_table();
      int n;
      n = usable_count();
      for (int i = 0; i < NUM_VERTICES; i++) begin
        parent_of[i] = VTX_W'(i);
      end
      weight_total = '0;
      merges_left  = (n == 0) ? '0 : CNT_W'(n - 1);
    endfunction

    function logic [VTX_W-1:0] find_root(logic [VTX_W-1:0] v);
      logic [VTX_W-1:0] root;
      logic [VTX_W-1:0] nxt;
      root = v;
      for (int g = 0; g < NUM_VERTICES && parent_of[root] != root; g++) begin
        root = parent_of[root];
      end
      for (int g = 0; g < NUM_VERTICES && parent_of[v] != v; g++) begin
        nxt          = parent_of[v];
        parent_of[v] = root;
        v            = nxt;
      end
      return root;
    endfunction

    function void note_request(logic kind, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                               logic [WGT_W-1:0] w);
      merge_result_t    r;
      logic [VTX_W-1:0] root_a;
      logic [VTX_W-1:0] root_b;
      logic [SUM_W:0]   sum;
      int               n;
      n = usable_count();
      r = '0;
      if (kind == REQ_CLEAR) begin
        clear_table();
      end else if (int'(a) >= n || int'(b) >= n) begin
        r.bad_vertex = 1'b1;
      end else begin
        root_a = find_root(a);
        root_b = find_root(b);
        if (root_a != root_b) begin
          parent_of[root_b] = root_a;
          r.merged          = 1'b1;
          sum               = {1'b0, weight_total} + (SUM_W + 1)'(w);
          weight_total      = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
          if (merges_left != 0) begin
            merges_left = merges_left - CNT_W'(1);
          end
        end
      end
      r.total_weight    = weight_total;
      r.components_left = merges_left;
      expected_q.push_back(r);
    endfunction

    function void check_result(merge_result_t got);
      merge_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result with no request outstanding: merged=%0d total=%0d left=%0d bad=%0d",
                   $time, got.merged, got.total_weight, got.components_left, got.bad_vertex);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.merged !== want.merged || got.total_weight !== want.total_weight ||
          got.components_left !== want.components_left ||
          got.bad_vertex !== want.bad_vertex) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: mismatch expected merged=%0d total=%0d left=%0d bad=%0d", $time,
                   want.merged, want.total_weight, want.components_left, want.bad_vertex);
          $display("%0t:          actual   merged=%0d total=%0d left=%0d bad=%0d", $time,
                   got.merged, got.total_weight, got.components_left, got.bad_vertex);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

  endclass

endpackage

/* dv/tb_kruskal_union_find_merge_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kruskal_union_find_merge_unit: testbench for the union-find merge unit
// A directed run covers clears, merges, repeated roots, deep chains, bad
// endpoints and unusual vertex counts. Random phases follow, each with its own
// vertex count, mostly well-formed edge streams in rising weight order, with
// heavy phases that drive the total into saturation. Both handshakes idle at
// random except in the last stretch.
// ----------------------------------------------------------------------------
module tb_kruskal_union_find_merge_unit;

  import kufm_pkg::*;
  import mst_check_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int CALM_ITEMS  = 150;
  localparam int STALL_LIMIT = 60000;
  localparam int DRAIN_WAIT  = 24;

  localparam logic [WGT_W-1:0] WEIGHT_MAX = '1;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_ready;
  logic             in_req_type;
  logic [VTX_W-1:0] in_first_vertex;
  logic [VTX_W-1:0] in_second_vertex;
  logic [WGT_W-1:0] in_edge_weight;
  logic             out_valid;
  logic             out_ready;
  logic             out_merged;
  logic [SUM_W-1:0] out_total_weight;
  logic [CNT_W-1:0] out_components_left;
  logic             out_bad_vertex;

  mst_scoreboard sb;
  logic          calm = 1'b0;
  int unsigned   items_sent = 0;
  int unsigned   quiet_cycles = 0;

  kruskal_union_find_merge_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_first_vertex     (in_first_vertex),
    .in_second_vertex    (in_second_vertex),
    .in_edge_weight      (in_edge_weight),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_merged          (out_merged),
    .out_total_weight    (out_total_weight),
    .out_components_left (out_components_left),
    .out_bad_vertex      (out_bad_vertex)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_request(input logic kind, input logic [VTX_W-1:0] a,
                              input logic [VTX_W-1:0] b, input logic [WGT_W-1:0] w);
    @(negedge clk);
    in_valid         <= 1'b1;
    in_req_type      <= kind;
    in_first_vertex  <= a;
    in_second_vertex <= b;
    in_edge_weight   <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, a, b, w);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      pause_sender($urandom_range(1, 14));
    end
  endtask

  task automatic write_vertex_count(input logic [CFG_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_vertex_count(value);
  endtask

  initial begin
    int span;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      span = $urandom_range(1, 14);
      if (!calm && $urandom_range(0, 2) == 0) begin
        repeat (span) @(negedge clk) out_ready <= 1'b0;
      end else begin
        repeat (span) @(negedge clk) out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_merged, out_total_weight, out_components_left, out_bad_vertex});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               phase;
    int               lim;
    int               pool;
    int               span;
    int               roll;
    logic             heavy;
    logic [CFG_W-1:0] count;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic [WGT_W-1:0] run_weight;
    logic [WGT_W-1:0] step;
    logic [WGT_W-1:0] noise;

    sb               = new();
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_req_type      = REQ_CLEAR;
    in_first_vertex  = '0;
    in_second_vertex = '0;
    in_edge_weight   = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    write_vertex_count(11'd1024);
    send_request(REQ_CLEAR, 10'd1023, 10'd1023, WEIGHT_MAX);
    send_request(REQ_EDGE, 10'd0, 10'd1023, '0);
    send_request(REQ_EDGE, 10'd1023, 10'd0, '0);
    send_request(REQ_EDGE, 10'd5, 10'd6, 40'd1);
    send_request(REQ_EDGE, 10'd6, 10'd0, WEIGHT_MAX);
    send_request(REQ_EDGE, 10'd11, 10'd10, WEIGHT_MAX);
    send_request(REQ_EDGE, 10'd12, 10'd11, WEIGHT_MAX);
    send_request(REQ_EDGE, 10'd13, 10'd12, WEIGHT_MAX);
    send_request(REQ_EDGE, 10'd14, 10'd13, WEIGHT_MAX);
    send_request(REQ_EDGE, 10'd10, 10'd10, WEIGHT_MAX);
    send_request(REQ_EDGE, 10'd512, 10'd10, WEIGHT_MAX);

    write_vertex_count(11'd0);
    send_request(REQ_EDGE, 10'd0, 10'd0, 40'd3);
    send_request(REQ_CLEAR, 10'd0, 10'd0, '0);
    send_request(REQ_EDGE, 10'd1023, 10'd0, 40'd3);

    write_vertex_count(11'd2047);
    send_request(REQ_CLEAR, 10'd0, 10'd0, '0);
    send_request(REQ_EDGE, 10'd1023, 10'd512, 40'h55_5555_5555);

    write_vertex_count(11'd1);
    send_request(REQ_CLEAR, 10'd0, 10'd0, '0);
    send_request(REQ_EDGE, 10'd0, 10'd0, 40'd7);
    send_request(REQ_EDGE, 10'd0, 10'd1, 40'd7);

    write_vertex_count(11'd2);
    send_request(REQ_CLEAR, 10'd0, 10'd0, '0);
    send_request(REQ_EDGE, 10'd1, 10'd3, 40'd9);
    send_request(REQ_EDGE, 10'd0, 10'd1, 40'd9);
    write_vertex_count(11'd4);
    send_request(REQ_EDGE, 10'd2, 10'd3, 40'd10);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      heavy = (phase == 1) || ($urandom_range(0, 9) == 0);
      roll  = $urandom_range(0, 99);
      if (heavy || roll < 40) begin
        count = 11'd1024;
      end else if (roll < 65) begin
        count = CFG_W'($urandom_range(2, 1024));
      end else if (roll < 85) begin
        count = CFG_W'($urandom_range(2, 16));
      end else if (roll < 90) begin
        count = 11'd0;
      end else if (roll < 95) begin
        count = 11'd1;
      end else begin
        count = CFG_W'($urandom_range(1025, 2047));
      end
      write_vertex_count(count);
      lim = (count > NUM_VERTICES) ? NUM_VERTICES : int'(count);

      if (phase == 0 || heavy || $urandom_range(0, 4) != 0) begin
        send_request(REQ_CLEAR, VTX_W'($urandom), VTX_W'($urandom), WGT_W'({$urandom, $urandom}));
      end

      pool = (lim == 0) ? 1 : lim;
      if (!heavy && lim > 64 && $urandom_range(0, 1) == 0) begin
        pool = $urandom_range(8, 64);
      end
      run_weight = heavy ? WEIGHT_MAX - WGT_W'($urandom_range(0, 4095))
                         : WGT_W'($urandom_range(0, 1000));
      span = heavy ? 360 : $urandom_range(20, 120);

      for (int i = 0; i < span && items_sent < ITEM_TARGET; i++) begin
        if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
          calm = 1'b1;
        end
        roll = $urandom_range(0, 99);
        step = WGT_W'(($urandom_range(0, 3) == 0) ? 0
                      : $urandom_range(1, heavy ? 16 : 100000));
        run_weight = (WEIGHT_MAX - run_weight > step) ? run_weight + step : WEIGHT_MAX;
        noise = WGT_W'({$urandom, $urandom});
        if (roll < 85) begin
          a = VTX_W'($urandom_range(0, pool - 1));
          b = VTX_W'($urandom_range(0, pool - 1));
          send_request(REQ_EDGE, a, b, run_weight);
        end else if (roll < 93 && lim < NUM_VERTICES) begin
          if ($urandom_range(0, 1) == 0) begin
            a = VTX_W'($urandom_range(lim, NUM_VERTICES - 1));
            b = VTX_W'($urandom);
          end else begin
            a = VTX_W'($urandom_range(0, pool - 1));
            b = VTX_W'($urandom_range(lim, NUM_VERTICES - 1));
          end
          send_request(REQ_EDGE, a, b, run_weight);
        end else if (roll < 98) begin
          send_request(REQ_EDGE, VTX_W'($urandom), VTX_W'($urandom), noise);
        end else begin
          send_request(REQ_CLEAR, VTX_W'($urandom), VTX_W'($urandom), noise);
        end
      end
      phase++;
    end

    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
